/* rtl/b255_pkg.sv */
// Shared types and constants for the binary to base-255 digit converter.
package b255_pkg;

    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 64;
    localparam int DIGIT_W = 8;

    localparam logic [BYTE_W:0] RADIX = 9'd255;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } b255_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] quot;
        logic [BYTE_W-1:0] rem;
    } b255_div_t;

endpackage

/* rtl/b255_num_if.sv */
// Request channels: the number to convert and the digits that come out.
interface b255_num_if import b255_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] value_low;
    logic [HALF_W-1:0] value_high;

    modport source (output valid, output value_low, output value_high, input ready);
    modport sink (input valid, input value_low, input value_high, output ready);
endinterface

interface b255_digit_if import b255_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output digit, output last, input ready);
    modport sink (input valid, input digit, input last, output ready);
endinterface

/* rtl/b255_byte_div.sv */
// One byte step of long division by 255.
module b255_byte_div import b255_pkg::*;
(
    input  logic [BYTE_W-1:0] rem_in,
    input  logic [BYTE_W-1:0] byte_in,
    output b255_div_t         result
);

    logic [BYTE_W:0] sum;
    logic            wrap;

    // rem*256 + b = rem*255 + (rem + b), and rem + b stays below 2*255.
    assign sum  = {1'b0, rem_in} + {1'b0, byte_in};
    assign wrap = (sum >= RADIX);

    always_comb
    begin
        if (wrap)
        begin
            result.quot = rem_in + BYTE_W'(1);
            result.rem  = BYTE_W'(sum - RADIX);
        end
        else
        begin
            result.quot = rem_in;
            result.rem  = sum[BYTE_W-1:0];
        end
    end

endmodule

/* rtl/binary_to_base255_digits.sv */
// Top level: converts a binary number into base-255 digits, least significant first.
//
//   Channel | Role | Payload                    | Per request
//   --------+------+----------------------------+-----------------------------
//   number  | sink | value_low[63:0],           | one number to convert
//           |      | value_high[63:0]           |
//   digits  | src  | digit[7:0], last           | n digits; last on the final
//
// Operation: each digit is one pass of long division by 255 over the number held
// in a byte-wide shift register, one byte per cycle unless a stall holds the pass
// at its last byte. A zero number takes one pass and gives no digit. The block
// takes no new number while it is still working on the previous one.
// Reset: rst_n clears the controller and the output valid flag at once.
// Stalls: a finished digit waits in the output register; the next pass runs
// but holds at its last byte until that register is free. A new number is
// taken as soon as the last pass of the previous one ends.
module binary_to_base255_digits import b255_pkg::*;
#(
    parameter int NUMBER_BYTES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    b255_num_if.sink      number,
    b255_digit_if.source  digits
);

    localparam int NUM_W = NUMBER_BYTES * BYTE_W;
    localparam int CNT_W = (NUMBER_BYTES > 1) ? $clog2(NUMBER_BYTES) : 1;

    b255_state_t         state_reg, state_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   rem_reg, rem_next;
    logic                in_nz_reg, in_nz_next;
    logic                q_nz_reg, q_nz_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic                last_reg, last_next;

    logic [BYTE_W-1:0]   top_byte;
    logic [NUM_W+BYTE_W-1:0] shifted;
    b255_div_t           div;
    logic                last_byte;
    logic                out_busy;
    logic                step_en;
    logic                in_nz_fin;
    logic                q_nz_fin;
    logic                emit;

    // The most significant byte enters the divider; its quotient byte enters
    // at the bottom, so after a full pass the quotient sits in place.
    assign top_byte = num_reg[NUM_W-1 -: BYTE_W];
    assign shifted  = {num_reg, div.quot};

    b255_byte_div u_div
    (
        .rem_in  (rem_reg),
        .byte_in (top_byte),
        .result  (div)
    );

    assign last_byte = (cnt_reg == CNT_W'(NUMBER_BYTES - 1));
    assign out_busy  = out_valid_reg && !digits.ready;
    assign step_en   = !(last_byte && out_busy);
    assign in_nz_fin = in_nz_reg || (top_byte != '0);
    assign q_nz_fin  = q_nz_reg || (div.quot != '0);

    assign number.ready = (state_reg == ST_IDLE);
    assign digits.valid = out_valid_reg;
    assign digits.digit = digit_reg;
    assign digits.last  = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        in_nz_next     = in_nz_reg;
        q_nz_next      = q_nz_reg;
        out_valid_next = out_valid_reg && !digits.ready;
        digit_next     = digit_reg;
        last_next      = last_reg;
        emit           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    // Bytes above NUMBER_BYTES are dropped by the size cast.
                    num_next   = NUM_W'({number.value_high, number.value_low});
                    cnt_next   = '0;
                    rem_next   = '0;
                    in_nz_next = 1'b0;
                    q_nz_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_en)
                begin
                    num_next   = shifted[NUM_W-1:0];
                    rem_next   = div.rem;
                    in_nz_next = in_nz_fin;
                    q_nz_next  = q_nz_fin;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (last_byte)
                    begin
                        cnt_next   = '0;
                        rem_next   = '0;
                        in_nz_next = 1'b0;
                        q_nz_next  = 1'b0;
                        // A pass over a nonzero dividend yields a digit; a zero
                        // quotient means that digit was the final one.
                        if (in_nz_fin)
                        begin
                            emit           = 1'b1;
                            out_valid_next = 1'b1;
                            digit_next     = div.rem + DIGIT_W'(1);
                            last_next      = !q_nz_fin;
                        end
                        if (!in_nz_fin || !q_nz_fin)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            in_nz_reg     <= 1'b0;
            q_nz_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            in_nz_reg     <= in_nz_next;
            q_nz_reg      <= q_nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
    end

    // The running remainder of a division by 255 never reaches 255.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 8'hFF)
        else $error("remainder out of range");

    // A digit is only produced when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_busy)
        else $error("digit written over a pending digit");

    // A new number always starts its first pass at the top byte.
    a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (number.valid && number.ready) |=> (state_reg == ST_DIV) && (cnt_reg == '0))
        else $error("pass did not start cleanly");

    // Every digit on the output is in the range one to 255.
    a_digit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_reg != '0))
        else $error("zero digit presented");

endmodule
